FILE: hw/rtl/ucb_pkg.sv
`timescale 1ns / 1ps
// Package for the UART command bus bridge: payload structs, opcodes, codes,
// register reset values and the job format passed from parser to sequencer.
// No dependencies.
package ucb_pkg;

   // Register widths and reset values
   localparam int unsigned TILE_BASE_W   = 32;
   localparam int unsigned TILE_STRIDE_W = 16;
   localparam int unsigned TILE_WORDS_W  = 9;
   localparam int unsigned RASTER_ADDR_W = 32;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned CSR_INDEX_W   = 2;

   localparam logic [TILE_BASE_W-1:0]   TILE_BASE_RST   = 32'h0500_0000;
   localparam logic [TILE_STRIDE_W-1:0] TILE_STRIDE_RST = 16'd16;
   localparam logic [TILE_WORDS_W-1:0]  TILE_WORDS_RST  = 9'd256;
   localparam logic [RASTER_ADDR_W-1:0] RASTER_ADDR_RST = 32'h0400_0000;

   // Default build parameters
   localparam int unsigned MAX_TILE_WORDS_DEF = 256;
   localparam int unsigned QUEUE_DEPTH_DEF    = 4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_STRIDE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_WORDS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RASTER_ADDR = 2'd3;

   // Input item function codes
   localparam logic [1:0] FUNC_PROMPT = 2'd0;
   localparam logic [1:0] FUNC_BYTE   = 2'd1;
   localparam logic [1:0] FUNC_RDATA  = 2'd2;
   localparam logic [1:0] FUNC_TICK   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // Command opcodes
   localparam logic [7:0] OP_WRITE_WORD = 8'h00;
   localparam logic [7:0] OP_READ_WORD  = 8'h01;
   localparam logic [7:0] OP_WRITE_TILE = 8'h02;
   localparam logic [7:0] OP_READ_TILE  = 8'h03;
   localparam logic [7:0] OP_RASTERIZE  = 8'h04;
   localparam logic [7:0] OP_END_FRAME  = 8'h05;

   localparam logic [7:0] PROMPT_BYTE = 8'h02;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  rx_byte;
      logic [31:0] read_data;
      logic        raster_busy;
   } ucb_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [31:0] bus_addr;
      logic [31:0] bus_data;
      logic        last;
   } ucb_rsp_type;

   typedef struct packed {
      logic [TILE_BASE_W-1:0]   tile_base;
      logic [TILE_STRIDE_W-1:0] tile_stride;
      logic [TILE_WORDS_W-1:0]  tile_words;
      logic [RASTER_ADDR_W-1:0] raster_ctrl_addr;
   } ucb_cfg_type;

   // Bus operation that follows the transmit bytes of a job
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_WRITE,
      TAIL_READ
   } ucb_tail_type;

   // One job: nbytes transmit bytes taken from data (low first), then the
   // tail bus operation. A write takes its data from data[31:0].
   typedef struct packed {
      logic [3:0]   nbytes;
      ucb_tail_type tail;
      logic [31:0]  addr;
      logic [63:0]  data;
   } ucb_job_type;

endpackage

FILE: hw/rtl/uart_command_bus_bridge.sv
`timescale 1ns / 1ps
// UART command bus bridge. Input transactions (start prompt, received byte,
// bus read data, tick) go through a parser that takes one per clock while
// its job queue has room, so back-to-back items are accepted at one per
// cycle. Each transaction yields at most one job; a sequencer drains the
// queue and delivers one result transaction per cycle while results are
// popped, up to 8 per job (a tile read word gives 4 bytes plus the next read
// request; a rasterize finish gives 8 count bytes). Sustained throughput is
// set by the result side, and the QUEUE_DEPTH-entry queue absorbs bursts.
// Configuration must be written through the csr port only while idle; the
// block itself does not enforce it. Depends on ucb_pkg and the ucb_* modules.
module uart_command_bus_bridge
   import ucb_pkg::*;
#(
   parameter int unsigned MAX_TILE_WORDS = MAX_TILE_WORDS_DEF,
   parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  ucb_req_type            req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   output ucb_rsp_type            rsp_data,
   input  logic                   rsp_pop,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ucb_cfg_type cfg;
   logic        job_push;
   ucb_job_type push_job;
   logic        queue_full;
   logic        job_valid;
   ucb_job_type head_job;
   logic        job_pop;

   assign req_full = queue_full;

   ucb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ucb_front #(
      .MAX_TILE_WORDS (MAX_TILE_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (push_job)
   );

   ucb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .head_job (head_job)
   );

   ucb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

FILE: hw/rtl/ucb_csr.sv
`timescale 1ns / 1ps
// Configuration registers of the UART command bus bridge.
// Depends on ucb_pkg.
module ucb_csr
   import ucb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output ucb_cfg_type            cfg
);

   ucb_cfg_type cfg_ff, cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TILE_BASE:   cfg_in.tile_base        = csr_wdata[TILE_BASE_W-1:0];
            CSR_TILE_STRIDE: cfg_in.tile_stride      = csr_wdata[TILE_STRIDE_W-1:0];
            CSR_TILE_WORDS:  cfg_in.tile_words       = csr_wdata[TILE_WORDS_W-1:0];
            CSR_RASTER_ADDR: cfg_in.raster_ctrl_addr = csr_wdata[RASTER_ADDR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_base        <= TILE_BASE_RST;
         cfg_ff.tile_stride      <= TILE_STRIDE_RST;
         cfg_ff.tile_words       <= TILE_WORDS_RST;
         cfg_ff.raster_ctrl_addr <= RASTER_ADDR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/ucb_front.sv
`timescale 1ns / 1ps
// Command parser: accepts input transactions, tracks the frame phase and
// turns each transaction into at most one job for the sequencer.
// Depends on ucb_pkg.
module ucb_front
   import ucb_pkg::*;
#(
   parameter int unsigned MAX_TILE_WORDS = MAX_TILE_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  ucb_cfg_type cfg,
   input  logic        req_push,
   input  ucb_req_type req_data,
   input  logic        queue_full,
   output logic        job_push,
   output ucb_job_type job
);

   localparam int unsigned WDW = $clog2(MAX_TILE_WORDS + 1);
   localparam int unsigned CW  = (WDW > TILE_WORDS_W) ? WDW : TILE_WORDS_W;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_WW_ADDR,
      PH_WW_DATA,
      PH_RW_ADDR,
      PH_RW_WAIT,
      PH_TILE_WR,
      PH_TILE_RD,
      PH_RASTER
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       idx_ff, idx_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      wa_ff, wa_in;
   logic [WDW-1:0]   done_ff, done_in;
   logic [63:0]      ticks_ff, ticks_in;

   logic             accept;
   logic [31:0]      wa_next;
   logic             word_full;
   logic [31:0]      addr_step;
   logic [CW-1:0]    tile_cnt;
   logic [CW-1:0]    tw_ext;
   logic [WDW-1:0]   done_next;
   logic             tile_end;
   logic [63:0]      ticks_next;

   assign accept = req_push & ~queue_full;

   // Operand byte assembly, little endian
   assign wa_next   = wa_ff | ({24'd0, req_data.rx_byte} << {idx_ff, 3'b000});
   assign word_full = (idx_ff == 2'd3);

   // Tile stepping; the word count is tile_words clamped to 1..MAX
   assign addr_step = addr_ff + {16'd0, cfg.tile_stride};
   assign tw_ext    = CW'(cfg.tile_words);
   always_comb begin
      if (tw_ext == '0) tile_cnt = CW'(1);
      else if (tw_ext > CW'(MAX_TILE_WORDS)) tile_cnt = CW'(MAX_TILE_WORDS);
      else tile_cnt = tw_ext;
   end
   assign done_next  = done_ff + WDW'(1);
   assign tile_end   = (CW'(done_next) >= tile_cnt);
   assign ticks_next = ticks_ff + 64'd1;

   // Phase decode and job build
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      wa_in    = wa_ff;
      done_in  = done_ff;
      ticks_in = ticks_ff;
      job_push = 1'b0;
      job      = '{nbytes: 4'd0, tail: TAIL_NONE, addr: 32'd0, data: 64'd0};

      if (accept) begin
         case (req_data.func)
            FUNC_PROMPT: begin
               if (phase_ff == PH_OPCODE) begin
                  job_push    = 1'b1;
                  job.nbytes  = 4'd1;
                  job.data    = {56'd0, PROMPT_BYTE};
               end
            end
            FUNC_BYTE: begin
               case (phase_ff)
                  PH_OPCODE: begin
                     idx_in  = 2'd0;
                     wa_in   = 32'd0;
                     done_in = '0;
                     case (req_data.rx_byte)
                        OP_WRITE_WORD: phase_in = PH_WW_ADDR;
                        OP_READ_WORD:  phase_in = PH_RW_ADDR;
                        OP_WRITE_TILE: begin
                           addr_in  = cfg.tile_base;
                           phase_in = PH_TILE_WR;
                        end
                        OP_READ_TILE: begin
                           addr_in  = cfg.tile_base;
                           phase_in = PH_TILE_RD;
                           job_push = 1'b1;
                           job.tail = TAIL_READ;
                           job.addr = cfg.tile_base;
                        end
                        OP_RASTERIZE: begin
                           ticks_in = 64'd0;
                           phase_in = PH_RASTER;
                           job_push = 1'b1;
                           job.tail = TAIL_WRITE;
                           job.addr = cfg.raster_ctrl_addr;
                           job.data = 64'd1;
                        end
                        OP_END_FRAME: begin
                           job_push   = 1'b1;
                           job.nbytes = 4'd1;
                           job.data   = {56'd0, PROMPT_BYTE};
                        end
                        default: phase_in = PH_OPCODE;
                     endcase
                  end
                  PH_WW_ADDR, PH_RW_ADDR, PH_WW_DATA, PH_TILE_WR: begin
                     idx_in = idx_ff + 2'd1;
                     wa_in  = wa_next;
                     if (word_full) begin
                        idx_in = 2'd0;
                        wa_in  = 32'd0;
                        case (phase_ff)
                           PH_WW_ADDR: begin
                              addr_in  = wa_next;
                              phase_in = PH_WW_DATA;
                           end
                           PH_RW_ADDR: begin
                              addr_in  = wa_next;
                              phase_in = PH_RW_WAIT;
                              job_push = 1'b1;
                              job.tail = TAIL_READ;
                              job.addr = wa_next;
                           end
                           PH_WW_DATA: begin
                              phase_in = PH_OPCODE;
                              job_push = 1'b1;
                              job.tail = TAIL_WRITE;
                              job.addr = addr_ff;
                              job.data = {32'd0, wa_next};
                           end
                           default: begin
                              // tile write word
                              job_push = 1'b1;
                              job.tail = TAIL_WRITE;
                              job.addr = addr_ff;
                              job.data = {32'd0, wa_next};
                              addr_in  = addr_step;
                              done_in  = done_next;
                              if (tile_end) phase_in = PH_OPCODE;
                           end
                        endcase
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
            FUNC_RDATA: begin
               if (phase_ff == PH_RW_WAIT) begin
                  phase_in   = PH_OPCODE;
                  job_push   = 1'b1;
                  job.nbytes = 4'd4;
                  job.data   = {32'd0, req_data.read_data};
               end else if (phase_ff == PH_TILE_RD) begin
                  addr_in    = addr_step;
                  done_in    = done_next;
                  job_push   = 1'b1;
                  job.nbytes = 4'd4;
                  job.data   = {32'd0, req_data.read_data};
                  if (tile_end) begin
                     phase_in = PH_OPCODE;
                  end else begin
                     job.tail = TAIL_READ;
                     job.addr = addr_step;
                  end
               end
            end
            default: begin
               // tick
               if (phase_ff == PH_RASTER) begin
                  ticks_in = ticks_next;
                  if (!req_data.raster_busy) begin
                     phase_in   = PH_OPCODE;
                     job_push   = 1'b1;
                     job.nbytes = 4'd8;
                     job.data   = ticks_next;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         idx_ff   <= 2'd0;
         addr_ff  <= 32'd0;
         wa_ff    <= 32'd0;
         done_ff  <= '0;
         ticks_ff <= 64'd0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         addr_ff  <= addr_in;
         wa_ff    <= wa_in;
         done_ff  <= done_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

FILE: hw/rtl/ucb_queue.sv
`timescale 1ns / 1ps
// Short job queue between parser and sequencer.
// Depends on ucb_pkg.
module ucb_queue
   import ucb_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ucb_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output ucb_job_type head_job
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNW = $clog2(DEPTH + 1);

   ucb_job_type     slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]  count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CNW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: hw/rtl/ucb_back.sv
`timescale 1ns / 1ps
// Result sequencer: expands one job into its transmit bytes and any tail bus operation,
// one result transaction per pop.
// Depends on ucb_pkg.
module ucb_back
   import ucb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  ucb_job_type job,
   output logic        job_pop,
   output logic        rsp_empty,
   output ucb_rsp_type rsp_data,
   input  logic        rsp_pop
);

   logic        cur_valid_ff, cur_valid_in;
   ucb_job_type cur_ff, cur_in;
   logic [3:0]  step_ff, step_in;

   logic [3:0]  total;
   logic        is_last;
   logic        advance;
   logic        load;

   assign total   = cur_ff.nbytes + ((cur_ff.tail != TAIL_NONE) ? 4'd1 : 4'd0);
   assign is_last = (step_ff == total - 4'd1);
   assign advance = cur_valid_ff & rsp_pop;
   assign load    = job_valid & (~cur_valid_ff | (advance & is_last));
   assign job_pop = load;

   // Current job and step
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_in       = job;
         step_in      = 4'd0;
      end else if (advance && is_last) begin
         cur_valid_in = 1'b0;
      end else if (advance) begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= 4'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Result fields for the current step
   always_comb begin
      rsp_data      = '{kind: KIND_TX, tx_byte: 8'd0, bus_addr: 32'd0,
                        bus_data: 32'd0, last: is_last};
      if (step_ff < cur_ff.nbytes) begin
         rsp_data.tx_byte = cur_ff.data[{step_ff[2:0], 3'b000} +: 8];
      end else begin
         case (cur_ff.tail)
            TAIL_WRITE: begin
               rsp_data.kind     = KIND_WRITE;
               rsp_data.bus_addr = cur_ff.addr;
               rsp_data.bus_data = cur_ff.data[31:0];
            end
            TAIL_READ: begin
               rsp_data.kind     = KIND_READ;
               rsp_data.bus_addr = cur_ff.addr;
            end
            default: rsp_data.kind = KIND_TX;
         endcase
      end
   end

   assign rsp_empty = ~cur_valid_ff;

endmodule

FILE: test/tb_uart_command_bus_bridge.sv
`timescale 1ns / 1ps
// Testbench for uart_command_bus_bridge: a directed table, then random command frames, checked
// against an in-bench model of the parser or typed-in results. Depends on ucb_pkg and the RTL.
module tb_uart_command_bus_bridge;
   import ucb_pkg::*;

   localparam int MAX_WORDS     = MAX_TILE_WORDS_DEF;
   localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH_DEF + 8;
   localparam int LONG_HOLD     = 300;
   // About 350 items, 8 results each at worst
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SIDE_SEND     = 0;
   localparam int SIDE_RECV     = 1;

   typedef enum logic [2:0] {
      PH_OPCODE, PH_WW_ADDR, PH_WW_DATA, PH_RW_ADDR,
      PH_RW_WAIT, PH_TILE_WR, PH_TILE_RD, PH_RASTER
   } parse_phase_type;

   // How a transaction's results are predicted: by the model, none, or one typed in
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_mode_type;

   typedef struct {
      ucb_req_type  item;
      chk_mode_type mode;
      ucb_rsp_type  rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   ucb_req_type            req_data = '0;
   logic                   req_full;
   logic                   rsp_empty;
   ucb_rsp_type            rsp_data;
   logic                   rsp_pop = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Travels with req_data: how the offered transaction is to be checked
   chk_mode_type           req_mode = CHK_MODEL;
   ucb_rsp_type            req_typed = '0;

   // Parser model state and register copy
   parse_phase_type parse_phase = PH_OPCODE;
   logic [1:0]   byte_pos = '0;
   logic [31:0]  cur_addr = '0;
   logic [31:0]  operand = '0;
   logic [8:0]   words_done = '0;
   logic [63:0]  tick_count = '0;
   ucb_cfg_type  regs = '{TILE_BASE_RST, TILE_STRIDE_RST, TILE_WORDS_RST, RASTER_ADDR_RST};

   ucb_rsp_type  step_transfers[$];
   ucb_rsp_type  due_transfers[$];
   stim_row_type directed_rows[$];

   int  mismatches = 0;
   int  cycle_count = 0;
   int  offered_count = 0;
   int  accepted_count = 0;
   int  live_items = 0;
   int  idle_run[2] = '{0, 0};
   bit  idle_calm[2] = '{1'b0, 1'b0};
   bit  hold_request = 1'b0;

   uart_command_bus_bridge uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Idle cycles before the next transaction; stretches with no idling now and then
   function automatic int draw_gap(input int side);
      if (idle_run[side] == 0) begin
         idle_calm[side] = ($urandom_range(0, 3) == 0);
         idle_run[side] = $urandom_range(8, 40);
      end
      idle_run[side]--;
      return idle_calm[side] ? 0 : $urandom_range(0, 18);
   endfunction

   // ---------------- parser model ----------------

   function automatic logic [8:0] tile_len();
      if (regs.tile_words == 9'd0) return 9'd1;
      if (regs.tile_words > MAX_WORDS) return 9'(MAX_WORDS);
      return regs.tile_words;
   endfunction

   // Shifts one operand byte in, little-endian; true once four are in
   function automatic bit gather_byte(input logic [7:0] b);
      operand = operand | ({24'h0, b} << (8 * byte_pos));
      if (byte_pos == 2'd3) begin
         byte_pos = 2'd0;
         return 1'b1;
      end
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
   endfunction

   // Steps to the next tile word; true when the transfer is complete
   function automatic bit advance_tile();
      cur_addr = cur_addr + {16'h0, regs.tile_stride};
      words_done = words_done + 9'd1;
      return words_done >= tile_len();
   endfunction

   task automatic emit(input logic [1:0] kind, input logic [7:0] tx,
                       input logic [31:0] addr, input logic [31:0] data);
      ucb_rsp_type r;
      r.kind = kind;
      r.tx_byte = tx;
      r.bus_addr = addr;
      r.bus_data = data;
      r.last = 1'b0;
      step_transfers.push_back(r);
   endtask

   task automatic emit_bytes(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) emit(KIND_TX, v[8*i +: 8], 32'h0, 32'h0);
   endtask

   // Results of one accepted input transaction, with the parser state advanced
   task automatic step_bridge(input ucb_req_type it);
      ucb_rsp_type tail;
      step_transfers.delete();
      case (it.func)
         FUNC_PROMPT: begin
            if (parse_phase == PH_OPCODE) emit(KIND_TX, PROMPT_BYTE, 32'h0, 32'h0);
         end
         FUNC_BYTE: begin
            case (parse_phase)
               PH_OPCODE: begin
                  byte_pos = 2'd0;
                  operand = '0;
                  words_done = '0;
                  case (it.rx_byte)
                     OP_WRITE_WORD: parse_phase = PH_WW_ADDR;
                     OP_READ_WORD: parse_phase = PH_RW_ADDR;
                     OP_WRITE_TILE: begin
                        cur_addr = regs.tile_base;
                        parse_phase = PH_TILE_WR;
                     end
                     OP_READ_TILE: begin
                        cur_addr = regs.tile_base;
                        parse_phase = PH_TILE_RD;
                        emit(KIND_READ, 8'h0, cur_addr, 32'h0);
                     end
                     OP_RASTERIZE: begin
                        tick_count = '0;
                        parse_phase = PH_RASTER;
                        emit(KIND_WRITE, 8'h0, regs.raster_ctrl_addr, 32'h1);
                     end
                     OP_END_FRAME: emit(KIND_TX, PROMPT_BYTE, 32'h0, 32'h0);
                     default: ;
                  endcase
               end
               PH_WW_ADDR: begin
                  if (gather_byte(it.rx_byte)) begin
                     cur_addr = operand;
                     operand = '0;
                     parse_phase = PH_WW_DATA;
                  end
               end
               PH_WW_DATA: begin
                  if (gather_byte(it.rx_byte)) begin
                     emit(KIND_WRITE, 8'h0, cur_addr, operand);
                     operand = '0;
                     parse_phase = PH_OPCODE;
                  end
               end
               PH_RW_ADDR: begin
                  if (gather_byte(it.rx_byte)) begin
                     cur_addr = operand;
                     operand = '0;
                     parse_phase = PH_RW_WAIT;
                     emit(KIND_READ, 8'h0, cur_addr, 32'h0);
                  end
               end
               PH_TILE_WR: begin
                  if (gather_byte(it.rx_byte)) begin
                     emit(KIND_WRITE, 8'h0, cur_addr, operand);
                     operand = '0;
                     if (advance_tile()) parse_phase = PH_OPCODE;
                  end
               end
               default: ;
            endcase
         end
         FUNC_RDATA: begin
            if (parse_phase == PH_RW_WAIT) begin
               emit_bytes({32'h0, it.read_data}, 4);
               parse_phase = PH_OPCODE;
            end else if (parse_phase == PH_TILE_RD) begin
               emit_bytes({32'h0, it.read_data}, 4);
               if (advance_tile()) parse_phase = PH_OPCODE;
               else emit(KIND_READ, 8'h0, cur_addr, 32'h0);
            end
         end
         default: begin
            // tick: counted while rasterizing, the tick that sees busy low included
            if (parse_phase == PH_RASTER) begin
               tick_count = tick_count + 64'd1;
               if (!it.raster_busy) begin
                  emit_bytes(tick_count, 8);
                  parse_phase = PH_OPCODE;
               end
            end
         end
      endcase
      if (step_transfers.size() > 0) begin
         tail = step_transfers.pop_back();
         tail.last = 1'b1;
         step_transfers.push_back(tail);
      end
   endtask

   // ---------------- checking ----------------

   task automatic flag_mismatch(input string what, input logic [79:0] got,
                                input logic [79:0] want);
      mismatches++;
      $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic compare_transfer(input ucb_rsp_type got);
      ucb_rsp_type want;
      if (due_transfers.size() == 0) begin
         flag_mismatch("result with nothing pending", got, '0);
         return;
      end
      want = due_transfers.pop_front();
      if (got.kind !== want.kind) flag_mismatch("kind", got.kind, want.kind);
      if (got.tx_byte !== want.tx_byte) flag_mismatch("tx_byte", got.tx_byte, want.tx_byte);
      if (got.bus_addr !== want.bus_addr)
         flag_mismatch("bus_addr", got.bus_addr, want.bus_addr);
      if (got.bus_data !== want.bus_data)
         flag_mismatch("bus_data", got.bus_data, want.bus_data);
      if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
   endtask

   // Both handshakes, sampled at the edge; prediction before comparison
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            step_bridge(req_data);
            case (req_mode)
               CHK_MODEL: foreach (step_transfers[i]) due_transfers.push_back(step_transfers[i]);
               CHK_ONE: due_transfers.push_back(req_typed);
               default: ;
            endcase
            accepted_count++;
         end
         if (rsp_pop && !rsp_empty) compare_transfer(rsp_data);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- result side ----------------

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(SIDE_RECV);
         // long hold-off so the queue fills and the input side stalls
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // ---------------- input side ----------------

   task automatic send_item(input ucb_req_type it, input chk_mode_type mode,
                            input ucb_rsp_type typed);
      int gap;
      gap = draw_gap(SIDE_SEND);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      req_mode <= mode;
      req_typed <= typed;
      do @(posedge clock); while (req_full);
      offered_count++;
      // model state must be current before the next transaction is chosen
      wait (accepted_count == offered_count);
   endtask

   // One transaction of the given function; the other fields carry random junk
   task automatic offer(input logic [1:0] func, input logic [31:0] value);
      ucb_req_type it;
      it.func = func;
      it.rx_byte = 8'($urandom_range(0, 255));
      it.read_data = $urandom;
      it.raster_busy = 1'($urandom_range(0, 1));
      case (func)
         FUNC_BYTE: it.rx_byte = value[7:0];
         FUNC_RDATA: it.read_data = value;
         FUNC_TICK: it.raster_busy = value[0];
         default: ;
      endcase
      send_item(it, CHK_MODEL, '0);
      live_items++;
   endtask

   task automatic send_noise();
      ucb_req_type it;
      it.func = 2'($urandom_range(0, 3));
      it.rx_byte = 8'($urandom_range(0, 255));
      it.read_data = $urandom;
      it.raster_busy = 1'($urandom_range(0, 1));
      send_item(it, CHK_MODEL, '0);
   endtask

   // Completes whatever frame element the parser is in the middle of
   task automatic finish_pending();
      while (parse_phase != PH_OPCODE) begin
         case (parse_phase)
            PH_RW_WAIT, PH_TILE_RD: offer(FUNC_RDATA, $urandom);
            PH_RASTER: offer(FUNC_TICK, ($urandom_range(0, 2) == 0) ? 32'd0 : 32'd1);
            default: offer(FUNC_BYTE, $urandom_range(0, 255));
         endcase
      end
   endtask

   // Mostly well-formed frame elements with random content, some noise
   task automatic random_command();
      int pick;
      finish_pending();
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         offer(FUNC_BYTE, OP_WRITE_WORD);
         repeat (8) offer(FUNC_BYTE, $urandom_range(0, 255));
      end else if (pick < 28) begin
         offer(FUNC_BYTE, OP_READ_WORD);
         repeat (4) offer(FUNC_BYTE, $urandom_range(0, 255));
         offer(FUNC_RDATA, $urandom);
      end else if (pick < 40) begin
         offer(FUNC_BYTE, OP_WRITE_TILE);
         while (parse_phase == PH_TILE_WR) offer(FUNC_BYTE, $urandom_range(0, 255));
      end else if (pick < 52) begin
         offer(FUNC_BYTE, OP_READ_TILE);
         while (parse_phase == PH_TILE_RD) offer(FUNC_RDATA, $urandom);
      end else if (pick < 66) begin
         offer(FUNC_BYTE, OP_RASTERIZE);
         repeat ($urandom_range(0, 5)) offer(FUNC_TICK, 32'd1);
         offer(FUNC_TICK, 32'd0);
      end else if (pick < 74) begin
         offer(FUNC_BYTE, OP_END_FRAME);
      end else if (pick < 80) begin
         offer(FUNC_PROMPT, 32'd0);
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 3)) send_noise();
      end else begin
         // broken element: an opcode followed by whatever comes
         offer(FUNC_BYTE, $urandom_range(0, 4));
         repeat ($urandom_range(1, 4)) send_noise();
      end
   endtask

   task automatic run_random(input int n);
      int target;
      target = live_items + n;
      while (live_items < target) random_command();
   endtask

   // ---------------- configuration ----------------

   // Waits until every result is out and the block has gone quiet
   task automatic settle();
      req_push <= 1'b0;
      while (due_transfers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_TILE_BASE: regs.tile_base = val;
         CSR_TILE_STRIDE: regs.tile_stride = val[15:0];
         CSR_TILE_WORDS: regs.tile_words = val[8:0];
         default: regs.raster_ctrl_addr = val;
      endcase
   endtask

   task automatic set_config(input logic [31:0] base, input logic [31:0] stride,
                             input logic [31:0] words, input logic [31:0] raddr);
      settle();
      write_reg(CSR_TILE_BASE, base);
      write_reg(CSR_TILE_STRIDE, stride);
      write_reg(CSR_TILE_WORDS, words);
      write_reg(CSR_RASTER_ADDR, raddr);
      csr_we <= 1'b0;
   endtask

   task automatic set_tile_words(input logic [31:0] words);
      settle();
      write_reg(CSR_TILE_WORDS, words);
      csr_we <= 1'b0;
   endtask

   task automatic add_row(input logic [1:0] func, input logic [7:0] b,
                          input logic [31:0] d, input logic busy, input chk_mode_type mode,
                          input logic [1:0] kind, input logic [7:0] tx,
                          input logic [31:0] addr, input logic [31:0] data);
      stim_row_type row;
      row.item = '{func, b, d, busy};
      row.mode = mode;
      row.rsp = '{kind, tx, addr, data, 1'b1};
      directed_rows.push_back(row);
   endtask

   // ---------------- test sequence ----------------

   initial begin
      // Directed table, register reset values in effect
      add_row(FUNC_PROMPT, 8'h00, 32'h0, 1'b0, CHK_ONE, KIND_TX, PROMPT_BYTE, 32'h0, 32'h0);
      // idle tick and stray read data are ignored
      add_row(FUNC_TICK, 8'hff, 32'hffffffff, 1'b1, CHK_NONE, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_RDATA, 8'h00, 32'h0, 1'b0, CHK_NONE, KIND_TX, 8'h0, 32'h0, 32'h0);
      // unknown opcode
      add_row(FUNC_BYTE, 8'hff, 32'h0, 1'b0, CHK_NONE, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, OP_END_FRAME, 32'h0, 1'b0, CHK_ONE, KIND_TX, PROMPT_BYTE, 32'h0, 32'h0);
      // write word to the top address; a prompt mid-frame is ignored
      add_row(FUNC_BYTE, OP_WRITE_WORD, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      repeat (4)
         add_row(FUNC_BYTE, 8'hff, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_PROMPT, 8'h00, 32'h0, 1'b0, CHK_NONE, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, 8'haa, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, 8'h55, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, 8'h00, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, 8'hff, 32'h0, 1'b0, CHK_ONE,
              KIND_WRITE, 8'h0, 32'hffffffff, 32'hff0055aa);
      // read word at address zero; a tick while waiting is ignored
      add_row(FUNC_BYTE, OP_READ_WORD, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      repeat (3)
         add_row(FUNC_BYTE, 8'h00, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_BYTE, 8'h00, 32'h0, 1'b0, CHK_ONE, KIND_READ, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_TICK, 8'h00, 32'h0, 1'b0, CHK_NONE, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_RDATA, 8'h00, 32'hffffffff, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      // rasterize: control write, one busy tick, then the count
      add_row(FUNC_BYTE, OP_RASTERIZE, 32'h0, 1'b0, CHK_ONE,
              KIND_WRITE, 8'h0, RASTER_ADDR_RST, 32'h1);
      add_row(FUNC_TICK, 8'h00, 32'h0, 1'b1, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);
      add_row(FUNC_TICK, 8'h00, 32'h0, 1'b0, CHK_MODEL, KIND_TX, 8'h0, 32'h0, 32'h0);

      while (reset) @(posedge clock);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].mode, directed_rows[i].rsp);

      // Top extremes: tile addresses and strides wrap
      set_config(32'hfffffff0, 32'h0000ffff, 32'd3, 32'hffffffff);
      hold_request = 1'b1;
      repeat (10) offer(FUNC_BYTE, OP_END_FRAME);
      run_random(10);

      // Bottom extremes: zero tile length is taken as one word
      set_config(32'h0, 32'h0, 32'h0, 32'h0);
      run_random(10);

      // Tile length shortened in the middle of a tile read ends it at once
      set_config($urandom, $urandom_range(0, 65535), 32'd8, $urandom);
      offer(FUNC_BYTE, OP_READ_TILE);
      repeat (3) offer(FUNC_RDATA, $urandom);
      set_tile_words(32'd2);
      offer(FUNC_RDATA, $urandom);
      run_random(6);

      // Oversized tile length clamps to the largest tile: one full tile read
      set_config($urandom, 32'd4, 32'd511, $urandom);
      offer(FUNC_BYTE, OP_READ_TILE);
      while (parse_phase == PH_TILE_RD) offer(FUNC_RDATA, $urandom);

      set_config($urandom, $urandom_range(0, 65535), $urandom_range(1, 6), $urandom);
      run_random(12);

      settle();
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
